// ===== hdl/scc_pkg.sv =====
`default_nettype none
package scc_pkg;
  localparam int unsigned SumW   = 15;
  localparam int unsigned CondW  = 22;
  localparam int unsigned PhaseW = 23;
  localparam int unsigned GainW  = 16;
  localparam int unsigned NumW   = 36;
  localparam int unsigned DenW   = 16;
  localparam logic [SumW-1:0] SumLimit = 15'd6900;
  localparam logic [GainW-1:0] GainReset = 16'd4588;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SORT,
    ST_EMA_MUL,
    ST_EMA_ADD,
    ST_OUT
  } state_t;

  // control from sequencer to the cell row
  typedef struct packed {
    logic load;     // load new value into one slot
    logic scan;     // rotate ring by one
    logic clr_rank; // start median count
  } row_ctl_t;
endpackage
`default_nettype wire

// ===== hdl/skin_conductance_conditioner_top.sv =====
`default_nettype none
// Skin conductance conditioner.
// Input channel: adc_sum with valid/ready. Output channel: sample_ok,
// conductance, median_level, tonic_level, phasic_level with valid/ready.
// smoothing_gain is written by cfg_we/cfg_data, only while idle: the user
// must keep to this, the block does not check it. One request at a time.
// A sum of 6900 or more gives its result (sample_ok=0, no state change)
// the cycle after acceptance. A valid sum runs a 36-step restoring divide;
// before the window is full its result shows once the divide is done.
// Once the window is full, a ring scan follows, where every cell counts
// lower-ranked values and the cell of rank MEDIAN_WINDOW/2 holds the
// median, then the EMA multiply and add states produce the result.
// Results sit in an output register; a stalled receiver holds the block
// in its output state and input ready stays low until the result leaves.
// Reset clears slot counter, fill flag and tonic value, gain = GainReset;
// window contents are not cleared (they are only read after all are written).
module skin_conductance_conditioner_top
  import scc_pkg::*;
#(
  parameter int unsigned MEDIAN_WINDOW = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [SumW-1:0]          adc_sum,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic                          sample_ok,
  output logic [CondW-1:0]              conductance,
  output logic [CondW-1:0]              median_level,
  output logic [CondW-1:0]              tonic_level,
  output logic signed [PhaseW-1:0]      phasic_level,
  input  wire logic                     cfg_we,
  input  wire logic [GainW-1:0]         cfg_data
);
  localparam int unsigned N    = MEDIAN_WINDOW;
  localparam int unsigned SlotW = $clog2(N);
  localparam int unsigned CntW  = $clog2(N + 1);
  localparam int unsigned Mid   = N / 2;

  state_t state, state_next;
  logic [GainW-1:0] gain;
  logic [SlotW-1:0] write_slot;
  logic             window_full;
  logic [CondW-1:0] tonic_value;
  logic             tonic_started;
  logic [SumW-1:0]  sum_r;
  logic [CntW-1:0]  scan_cnt;
  logic [CondW-1:0] cond_r, med_r;
  logic signed [39:0] prod_r;
  row_ctl_t ctl;

  // divider: dividend taken at start from the live sum, divisor held in sum_r
  logic div_start, div_done;
  logic [CondW-1:0] quo;
  logic [NumW-1:0] num;
  logic [DenW-1:0] den;
  logic [SumW-1:0] diffs;
  always_comb begin
    diffs = SumLimit - adc_sum;
    num = {20'(diffs) * 20'd100, 16'd0};
    den = DenW'(16'd20480 + {sum_r[13:0], 1'b0});
  end
  scc_divider u_div (.clk, .start(div_start), .num, .den, .done(div_done), .quo);

  // cell row: slot i loaded directly; during scan values rotate i -> i+1
  logic [CondW-1:0] vals [N];
  logic [CondW-1:0] owns [N];
  logic [CntW-1:0]  ranks [N];
  logic [N-1:0]     tag;
  for (genvar i = 0; i < N; i++) begin : g_cell
    row_ctl_t c;
    localparam int unsigned Prev = (i + N - 1) % N;
    always_comb begin
      c = ctl;
      c.load = ctl.load && (write_slot == SlotW'(i));
    end
    // passing value originated in a lower slot when it has not wrapped yet
    assign tag[i] = (scan_cnt <= CntW'(i));
    scc_cell #(.CntW(CntW)) u_cell (
      .clk, .ctl(c), .in_val(vals[Prev]), .in_tag(tag[i]),
      .load_val(quo), .val(vals[i]), .own(owns[i]), .rank(ranks[i])
    );
  end

  // median pick: cell whose rank equals the middle
  logic [CondW-1:0] med_pick;
  always_comb begin
    med_pick = '0;
    for (int i = 0; i < N; i++) begin
      if (ranks[i] == CntW'(Mid)) med_pick = owns[i];
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:    if (in_valid) state_next = (adc_sum >= SumLimit) ? ST_OUT : ST_DIV;
      ST_DIV:     if (div_done) state_next = (window_full ||
                    write_slot == SlotW'(N-1)) ? ST_SORT : ST_OUT;
      ST_SORT:    if (scan_cnt == CntW'(N)) state_next = ST_EMA_MUL;
      ST_EMA_MUL: state_next = ST_EMA_ADD;
      ST_EMA_ADD: state_next = ST_OUT;
      ST_OUT:     if (out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
    div_start = (state == ST_IDLE) && in_valid && (adc_sum < SumLimit);
    ctl.load  = (state == ST_DIV) && div_done;
    ctl.clr_rank = (state == ST_SORT) && (scan_cnt == '0);
    ctl.scan  = (state == ST_SORT) && (scan_cnt != '0);
  end

  logic signed [CondW:0] ema_diff;
  logic signed [CondW:0] ema_step;
  always_comb begin
    ema_diff = $signed({1'b0, med_r}) - $signed({1'b0, tonic_value});
    ema_step = CondW'(0) + (CondW+1)'(prod_r >>> 16);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE; gain <= GainReset; write_slot <= '0;
      window_full <= 1'b0; tonic_value <= '0; tonic_started <= 1'b0;
      scan_cnt <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) gain <= cfg_data;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          sum_r <= adc_sum;
          sample_ok <= (adc_sum < SumLimit);
          conductance <= '0; median_level <= '0; phasic_level <= '0;
          tonic_level <= tonic_value;
        end
        ST_DIV: if (div_done) begin
          cond_r <= quo;
          scan_cnt <= '0;
          if (write_slot == SlotW'(N-1)) begin
            write_slot <= '0; window_full <= 1'b1;
          end else begin
            write_slot <= write_slot + SlotW'(1);
          end
          if (!(window_full || write_slot == SlotW'(N-1))) begin
            if (!tonic_started) begin
              tonic_value <= quo; tonic_started <= 1'b1;
            end
            conductance <= quo; median_level <= quo;
            tonic_level <= tonic_started ? tonic_value : quo;
            phasic_level <= $signed({1'b0, quo}) -
              $signed({1'b0, (tonic_started ? tonic_value : quo)});
          end
        end
        ST_SORT: begin
          scan_cnt <= scan_cnt + CntW'(1);
          if (scan_cnt == CntW'(N)) begin
            med_r <= med_pick;
            if (!tonic_started) begin
              tonic_value <= med_pick; tonic_started <= 1'b1;
            end
          end
        end
        ST_EMA_MUL: prod_r <= 40'($signed({1'b0, gain}) * ema_diff);
        ST_EMA_ADD: begin
          tonic_value <= CondW'($signed({1'b0, tonic_value}) + ema_step);
          conductance <= cond_r; median_level <= med_r;
          tonic_level <= CondW'($signed({1'b0, tonic_value}) + ema_step);
          phasic_level <= $signed({1'b0, cond_r}) -
            $signed({1'b0, CondW'($signed({1'b0, tonic_value}) + ema_step)});
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ===== hdl/scc_cell.sv =====
`default_nettype none
// One window slot. During a scan the ring rotates; each cell counts how many
// passing values rank below its own (ties broken by slot order).
module scc_cell
  import scc_pkg::*;
#(
  parameter int unsigned CntW = 5
) (
  input  wire logic             clk,
  input  wire scc_pkg::row_ctl_t ctl,
  input  wire logic [CondW-1:0] in_val,
  input  wire logic             in_tag,   // passing value came from a lower slot
  input  wire logic [CondW-1:0] load_val,
  output logic      [CondW-1:0] val,
  output logic      [CondW-1:0] own,
  output logic      [CntW-1:0]  rank
);
  logic [CondW-1:0] pass;
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      own  <= load_val;
      pass <= load_val;
    end else if (ctl.clr_rank) begin
      pass <= own;
      rank <= '0;
    end else if (ctl.scan) begin
      pass <= in_val;
      if (in_val < own || (in_val == own && in_tag)) begin
        rank <= rank + CntW'(1);
      end
    end
  end
  assign val = pass;
endmodule
`default_nettype wire

// ===== hdl/scc_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module scc_divider
  import scc_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            start,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic                 done,
  output logic      [CondW-1:0] quo
);
  logic [NumW-1:0] q;
  logic [DenW:0]   r;
  logic [5:0]      cnt;
  logic [DenW:0]   trial;
  logic            busy;
  always_comb trial = {r[DenW-1:0], q[NumW-1]};
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      q <= num; r <= '0; cnt <= 6'(NumW-1); busy <= 1'b1;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        r <= trial - {1'b0, den};
        q <= {q[NumW-2:0], 1'b1};
      end else begin
        r <= trial;
        q <= {q[NumW-2:0], 1'b0};
      end
      if (cnt == '0) begin
        busy <= 1'b0; done <= 1'b1;
      end
      cnt <= cnt - 6'd1;
    end
  end
  assign quo = q[CondW-1:0];
endmodule
`default_nettype wire

// ===== hdl/scc_checker.sv =====
`default_nettype none
module scc_checker
  import scc_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic sample_ok,
  input wire logic [CondW-1:0] conductance,
  input wire logic [CondW-1:0] tonic_level,
  input wire logic signed [PhaseW-1:0] phasic_level
);
  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second request taken");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(conductance))
    else $error("result dropped");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sample_ok |-> conductance == '0 && phasic_level == '0)
    else $error("rejected sample not zeroed");
  a_phasic: assert property (@(posedge clk) disable iff (rst)
    out_valid && sample_ok |->
      phasic_level == $signed({1'b0, conductance}) - $signed({1'b0, tonic_level}))
    else $error("phasic mismatch");
endmodule

bind skin_conductance_conditioner_top scc_checker u_chk (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sample_ok,
  .conductance, .tonic_level, .phasic_level
);
`default_nettype wire

// ===== dv/skin_conductance_conditioner_top_test.sv =====
`timescale 1ns / 1ps
module skin_conductance_conditioner_top_test;
  import scc_pkg::*;

  localparam int unsigned WinDepth  = 9;
  localparam int unsigned LimitCyc  = 1500000;
  localparam int unsigned DrainWait = 200;

  // One expected result of the conditioner.
  typedef struct packed {
    logic                     ok;
    logic [CondW-1:0]         cond;
    logic [CondW-1:0]         med;
    logic [CondW-1:0]         tonic;
    logic signed [PhaseW-1:0] phasic;
  } gsr_result_t;

  // Tracks the conditioner state and keeps the queue of predicted results.
  class gsr_scoreboard;
    logic [CondW-1:0] window [WinDepth];
    int unsigned      slot;
    bit               full;
    logic [CondW-1:0] tonic;
    bit               started;
    logic [GainW-1:0] gain;
    gsr_result_t      pending[$];
    int unsigned      errors;

    function void clear();
      slot    = 0;
      full    = 0;
      tonic   = '0;
      started = 0;
      gain    = GainReset;
      pending.delete();
      errors  = 0;
    endfunction

    function logic [CondW-1:0] window_median();
      logic [CondW-1:0] s [WinDepth];
      logic [CondW-1:0] t;
      s = window;
      for (int i = 0; i < WinDepth; i++)
        for (int j = 0; j + 1 < WinDepth - i; j++)
          if (s[j] > s[j+1]) begin
            t = s[j];
            s[j] = s[j+1];
            s[j+1] = t;
          end
      return s[WinDepth/2];
    endfunction

    // Fold one accepted sum into the state and queue its result.
    function void note_request(logic [SumW-1:0] sum);
      gsr_result_t   r;
      longint        num, den, diff, prod, stp;
      logic [CondW-1:0] c, m;
      if (sum >= SumLimit) begin
        r = '0;
        r.tonic = tonic;
        pending.push_back(r);
        return;
      end
      num = 64'd100 * (6900 - longint'(sum)) * 65536;
      den = 20480 + 2 * longint'(sum);
      c = CondW'(num / den);
      window[slot] = c;
      slot++;
      if (slot >= WinDepth) begin
        slot = 0;
        full = 1;
      end
      if (!full) begin
        if (!started) begin
          tonic = c;
          started = 1;
        end
        m = c;
      end else begin
        m = window_median();
        if (!started) begin
          tonic = m;
          started = 1;
        end
        diff = longint'(m) - longint'(tonic);
        prod = longint'(gain) * diff;
        stp  = prod >>> 16;  // floor toward minus infinity
        tonic = CondW'(longint'(tonic) + stp);
      end
      r.ok     = 1'b1;
      r.cond   = c;
      r.med    = m;
      r.tonic  = tonic;
      r.phasic = PhaseW'(longint'(c) - longint'(tonic));
      pending.push_back(r);
    endfunction

    function void check_result(gsr_result_t got);
      gsr_result_t exp_r;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.ok !== exp_r.ok) begin
        $display("%0t: sample_ok exp %0d got %0d", $time, exp_r.ok, got.ok);
        errors++;
      end
      if (got.cond !== exp_r.cond) begin
        $display("%0t: conductance exp %0d got %0d", $time, exp_r.cond, got.cond);
        errors++;
      end
      if (got.med !== exp_r.med) begin
        $display("%0t: median_level exp %0d got %0d", $time, exp_r.med, got.med);
        errors++;
      end
      if (got.tonic !== exp_r.tonic) begin
        $display("%0t: tonic_level exp %0d got %0d", $time, exp_r.tonic, got.tonic);
        errors++;
      end
      if (got.phasic !== exp_r.phasic) begin
        $display("%0t: phasic_level exp %0d got %0d", $time, exp_r.phasic,
                 got.phasic);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [SumW-1:0]          adc_sum = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     sample_ok;
  logic [CondW-1:0]         conductance;
  logic [CondW-1:0]         median_level;
  logic [CondW-1:0]         tonic_level;
  logic signed [PhaseW-1:0] phasic_level;
  logic                     cfg_we = 1'b0;
  logic [GainW-1:0]         cfg_data = '0;

  gsr_scoreboard sb;
  int unsigned   send_idle_pct;   // sender gap chance, percent
  int unsigned   recv_idle_pct;   // receiver stall chance, percent
  longint unsigned cycle_count;

  skin_conductance_conditioner_top #(.MEDIAN_WINDOW(WinDepth)) DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .adc_sum(adc_sum),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample_ok(sample_ok), .conductance(conductance),
    .median_level(median_level), .tonic_level(tonic_level),
    .phasic_level(phasic_level),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Watchdog: the slowest correct run is far below this.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > LimitCyc) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Receiver: random stalls, checks every accepted result.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      sb.check_result({sample_ok, conductance, median_level, tonic_level,
                       phasic_level});
    if (rst)
      out_ready <= 1'b0;
    else
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Drive one request; the predictor is updated at the accepting edge.
  // Valid stays up after acceptance; the next call or drain() drops it.
  task automatic send_sum(logic [SumW-1:0] sum);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    adc_sum  <= sum;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(sum);
  endtask

  // Wait for all outstanding results, then let the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task automatic write_gain(logic [GainW-1:0] g);
    drain();
    cfg_we   <= 1'b1;
    cfg_data <= g;
    @(posedge clk);
    cfg_we   <= 1'b0;
    sb.gain = g;
  endtask

  // Mostly valid sums (small, mid, near the limit), some overrange.
  function automatic logic [SumW-1:0] pick_sum();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 8)  return SumW'($urandom_range(32767, 6900));
    if (k < 15) return SumW'($urandom_range(6899, 6800));
    if (k < 22) return SumW'($urandom_range(100, 0));
    return SumW'($urandom_range(6899, 0));
  endfunction

  task automatic random_phase(int unsigned n, int unsigned s_pct, int unsigned r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n; i++) begin
      send_sum(pick_sum());
      // stretch with no idling at all inside each phase
      if (i == n / 2) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (i == n / 2 + 40) begin
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
      end
    end
  endtask

  initial begin
    sb = new();
    sb.clear();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: overrange before any valid sample, then field extremes
    // and the fill of the window, including the completing sample.
    send_sum(15'd6900);
    send_sum(15'h7FFF);
    send_sum(15'd0);
    send_sum(15'd6899);
    send_sum(15'd20460);
    send_sum(15'd6901);
    send_sum(15'd1);
    send_sum(15'd3450);
    send_sum(15'h5555);
    send_sum(15'h2AAA);
    send_sum(15'd1000);
    send_sum(15'd6000);
    send_sum(15'd200);
    send_sum(15'd4000);
    send_sum(15'd7000);
    send_sum(15'd0);
    send_sum(15'd6899);
    send_sum(15'd2500);

    // Gain extremes, each followed by a few samples.
    write_gain(16'd0);
    for (int i = 0; i < 4; i++) send_sum(pick_sum());
    write_gain(16'hFFFF);
    for (int i = 0; i < 4; i++) send_sum(pick_sum());

    random_phase(350, 31, 71);
    // hold the sender until the block has answered everything
    drain();
    write_gain(16'(($urandom_range(65535))));
    random_phase(350, 71, 31);
    write_gain(16'd1);
    random_phase(150, 0, 0);
    write_gain(GainReset);
    random_phase(180, 0, 0);

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end
endmodule

// ===== files.f =====
hdl/scc_pkg.sv
hdl/scc_cell.sv
hdl/scc_divider.sv
hdl/skin_conductance_conditioner_top.sv
hdl/scc_checker.sv
dv/skin_conductance_conditioner_top_test.sv
